[rtl/bitmap_block_allocator_top_defines.svh]
// Assertion macros shared by the allocator checker
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is low
`define BBAL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbal check failed");

// Next-cycle implication, sampled on clk, off while reset is low
`define BBAL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbal check failed");

`endif

[rtl/bbal_pkg.sv]
// Package: sizes, request and status codes, and the clear-bit search for the allocator
`timescale 1ns / 1ps

package bbal_pkg;

	// Map geometry; WORD_BITS is a power of two so a block splits into word and bit by slicing
	localparam int NUM_BLOCKS = 4096;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BLK_W      = ADDR_W + BIT_W;
	localparam int FREE_W     = $clog2(NUM_BLOCKS + 1);

	// Fixed field widths at the ports
	localparam int MODE_W     = 2;
	localparam int IDX_W      = 12;
	localparam int FREE_OUT_W = 13;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_READ    = 2'd2,
		MODE_WRITE   = 2'd3
	} mode_t;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} fz_t;

	// Lowest clear bit of a map word
	function automatic fz_t first_zero(input logic [WORD_BITS-1:0] w);
		fz_t r;
		r.found = 1'b0;
		r.pos   = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (!w[k]) begin
				r.found = 1'b1;
				r.pos   = BIT_W'(k);
			end
		end
		return r;
	endfunction

endpackage

[rtl/bbal_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps

module bbal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/bbal_ctrl.sv]
// Request sequencer: bitmap read-modify-write, first-fit scan, free count and result register
`timescale 1ns / 1ps

module bbal_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bbal_pkg::MODE_W-1:0]        mode,
	input  logic [bbal_pkg::IDX_W-1:0]         block_index,
	input  logic                               bit_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bbal_pkg::IDX_W-1:0]         result_block,
	output logic                               result_bit,
	output logic                               status,
	output logic [bbal_pkg::FREE_OUT_W-1:0]    free_blocks,
	output logic                               ram_rd_en,
	output logic [bbal_pkg::ADDR_W-1:0]        ram_rd_addr,
	input  logic [bbal_pkg::WORD_BITS-1:0]     ram_rd_data,
	output logic                               ram_wr_en,
	output logic [bbal_pkg::ADDR_W-1:0]        ram_wr_addr,
	output logic [bbal_pkg::WORD_BITS-1:0]     ram_wr_data
);

	import bbal_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RMW,
		S_FIN
	} state_t;

	state_t                 state_q;
	mode_t                  mode_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   val_q;
	logic [ADDR_W:0]        scan_addr_q;
	logic [ADDR_W-1:0]      rd_addr_s1;
	logic                   rd_vld_s1;
	logic [MAP_WORDS-1:0]   vld_q;
	logic [FREE_W-1:0]      free_q;
	logic [IDX_W-1:0]       res_block_q;
	logic                   res_bit_q;
	logic                   res_status_q;
	logic                   out_valid_q;
	logic [IDX_W-1:0]       out_block_q;
	logic                   out_bit_q;
	logic                   out_status_q;
	logic [FREE_OUT_W-1:0]  out_free_q;

	logic [WORD_BITS-1:0]   word_s1;
	logic [BIT_W-1:0]       bit_sel;
	logic                   cur_bit;
	fz_t                    fz;
	logic [BLK_W-1:0]       found_blk;
	logic                   found_ok;
	logic                   word_hit;
	logic                   last_word;
	logic                   in_range;
	logic                   out_free;

	// Never-written words read as all free
	assign word_s1   = rd_vld_s1 ? ram_rd_data : '0;
	assign bit_sel   = idx_q[BIT_W-1:0];
	assign cur_bit   = word_s1[bit_sel];
	assign fz        = first_zero(word_s1);
	assign found_blk = {rd_addr_s1, fz.pos};
	assign found_ok  = fz.found && (32'(found_blk) < 32'(NUM_BLOCKS));
	assign word_hit  = (word_s1 != '1);
	assign last_word = (rd_addr_s1 == ADDR_W'(MAP_WORDS - 1));
	assign in_range  = (32'(idx_q) < 32'(NUM_BLOCKS));
	assign out_free  = !out_valid_q || out_ready;

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_block = out_block_q;
	assign result_bit   = out_bit_q;
	assign status       = out_status_q;
	assign free_blocks  = out_free_q;

	// Drive the bitmap RAM ports
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = rd_addr_s1;
		ram_wr_data = word_s1;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ram_rd_en = 1'b1;
					if (mode_t'(mode) != MODE_ALLOC) begin
						ram_rd_addr = ADDR_W'(block_index >> BIT_W);
					end
				end
			end
			S_SCAN: begin
				if (scan_addr_q < (ADDR_W + 1)'(MAP_WORDS)) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = scan_addr_q[ADDR_W-1:0];
				end
				if (word_hit && found_ok) begin
					ram_wr_en = 1'b1;
					ram_wr_data[fz.pos] = 1'b1;
				end
			end
			S_RMW: begin
				if (in_range && mode_q != MODE_READ) begin
					ram_wr_en = 1'b1;
					ram_wr_data[bit_sel] = (mode_q == MODE_WRITE) ? val_q : 1'b0;
				end
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Sequence requests and hold state, free count and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vld_q       <= '0;
			free_q      <= FREE_W'(NUM_BLOCKS);
			out_valid_q <= 1'b0;
		end else begin
			if (ram_rd_en) begin
				rd_addr_s1 <= ram_rd_addr;
				rd_vld_s1  <= vld_q[ram_rd_addr];
			end
			if (ram_wr_en) begin
				vld_q[ram_wr_addr] <= 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q      <= mode_t'(mode);
						idx_q       <= block_index;
						val_q       <= bit_value;
						scan_addr_q <= (ADDR_W + 1)'(1);
						if (mode_t'(mode) == MODE_ALLOC) begin
							if (free_q == '0) begin
								res_block_q  <= '0;
								res_bit_q    <= 1'b0;
								res_status_q <= ST_FULL;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							state_q <= S_RMW;
						end
					end
				end
				S_SCAN: begin
					// One map word arrives per cycle; stop at the first word with a clear bit
					scan_addr_q <= scan_addr_q + (ADDR_W + 1)'(1);
					if (word_hit) begin
						if (found_ok) begin
							res_block_q  <= IDX_W'(found_blk);
							res_bit_q    <= 1'b1;
							res_status_q <= ST_OK;
							free_q       <= free_q - FREE_W'(1);
						end else begin
							res_block_q  <= '0;
							res_bit_q    <= 1'b0;
							res_status_q <= ST_FULL;
						end
						state_q <= S_FIN;
					end else if (last_word) begin
						res_block_q  <= '0;
						res_bit_q    <= 1'b0;
						res_status_q <= ST_FULL;
						state_q      <= S_FIN;
					end
				end
				S_RMW: begin
					res_block_q  <= idx_q;
					res_status_q <= ST_OK;
					res_bit_q    <= 1'b0;
					if (in_range) begin
						unique case (mode_q)
							MODE_RELEASE: begin
								if (free_q < FREE_W'(NUM_BLOCKS)) begin
									free_q <= free_q + FREE_W'(1);
								end
							end
							MODE_READ:  res_bit_q <= cur_bit;
							MODE_WRITE: res_bit_q <= val_q;
							MODE_ALLOC: begin
							end
							default: begin
							end
						endcase
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// Hand the result over once the output register is free
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_block_q  <= res_block_q;
						out_bit_q    <= res_bit_q;
						out_status_q <= res_status_q;
						out_free_q   <= FREE_OUT_W'(free_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/bitmap_block_allocator_top.sv]
// Top level of the first-fit bitmap block allocator
`timescale 1ns / 1ps

// First-fit bitmap block allocator. One occupancy bit per block (1 occupied) lives in a
// 128 x 32 synchronous RAM, one word per 32 blocks, next to a free-block counter. Requests
// are handled one at a time. Allocate reads the map through the RAM's single read port one
// word per cycle from word 0 and stops at the first word with a clear bit, which it sets. Its
// result passes through S_FIN to the output register, and the next request is accepted once
// the sequencer is back in S_IDLE. A free count of zero fails without a scan. Release, read
// and write do one read-modify-write of the addressed word in S_RMW and reach the output
// register through S_FIN. A result waits in the output register while the next request is
// accepted. Reset frees every block at once through per-word valid flags; no clearing pass
// runs.

module bitmap_block_allocator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bbal_pkg::MODE_W-1:0]        mode,
	input  logic [bbal_pkg::IDX_W-1:0]         block_index,
	input  logic                               bit_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bbal_pkg::IDX_W-1:0]         result_block,
	output logic                               result_bit,
	output logic                               status,
	output logic [bbal_pkg::FREE_OUT_W-1:0]    free_blocks
);

	import bbal_pkg::*;

	logic                  ram_rd_en;
	logic [ADDR_W-1:0]     ram_rd_addr;
	logic [WORD_BITS-1:0]  ram_rd_data;
	logic                  ram_wr_en;
	logic [ADDR_W-1:0]     ram_wr_addr;
	logic [WORD_BITS-1:0]  ram_wr_data;

	// Request sequencer
	bbal_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.block_index  (block_index),
		.bit_value    (bit_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_block (result_block),
		.result_bit   (result_bit),
		.status       (status),
		.free_blocks  (free_blocks),
		.ram_rd_en    (ram_rd_en),
		.ram_rd_addr  (ram_rd_addr),
		.ram_rd_data  (ram_rd_data),
		.ram_wr_en    (ram_wr_en),
		.ram_wr_addr  (ram_wr_addr),
		.ram_wr_data  (ram_wr_data)
	);

	// Occupancy bitmap store
	bbal_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

[rtl/bbal_checker.sv]
// Port-level checker for the allocator and its bind to the top level
`timescale 1ns / 1ps
`include "bitmap_block_allocator_top_defines.svh"

module bbal_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [bbal_pkg::MODE_W-1:0]        mode,
	input  logic [bbal_pkg::IDX_W-1:0]         block_index,
	input  logic                               bit_value,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [bbal_pkg::IDX_W-1:0]         result_block,
	input  logic                               result_bit,
	input  logic                               status,
	input  logic [bbal_pkg::FREE_OUT_W-1:0]    free_blocks
);

	import bbal_pkg::*;

	logic [MODE_W+IDX_W:0]       in_payload;
	logic [IDX_W+FREE_OUT_W+1:0] out_payload;

	assign in_payload  = {mode, block_index, bit_value};
	assign out_payload = {result_block, result_bit, status, free_blocks};

	// Hold a stalled request
	`BBAL_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_payload))

	// Hold a stalled result
	`BBAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

	// Take one request at a time
	`BBAL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

	// A failed allocate reports block zero, bit clear
	`BBAL_ASSERT_NOW(a_fail_zero, out_valid && status == ST_FULL, result_block == '0 && !result_bit)

	// Free count never exceeds the map size
	`BBAL_ASSERT_NOW(a_free_bound, out_valid, 32'(free_blocks) <= 32'(NUM_BLOCKS))

endmodule

bind bitmap_block_allocator_top bbal_checker u_bbal_checker (.*);
